// ===== rtl/pfr_pkg.sv =====
package pfr_pkg;

   // Frame header layout: three length bytes, little-endian, then one sequence byte.
   localparam int HEADER_BYTES = 4;
   localparam int LEN_W        = 24;
   localparam int SEQ_W        = 8;
   localparam int BYTE_W       = 8;
   localparam int SIZE_W       = 32;

   // Header byte counter position of the sequence byte.
   localparam logic [1:0] HDR_SEQ_IDX = 2'(HEADER_BYTES - 1);

   // Payload width of the result stream: 65 field bits rounded up to whole bytes.
   localparam int RSP_DATA_W = 72;

   // Reset value of the maximum frame size register.
   localparam logic [LEN_W-1:0] MAX_FRAME_RESET = {LEN_W{1'b1}};

   // Saturation value of the message byte count.
   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   // One result beat, as produced by the parser.
   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_out;
      logic              message_done;
      logic [SEQ_W-1:0]  first_seq;
      logic [SEQ_W-1:0]  last_seq;
      logic [SIZE_W-1:0] message_bytes;
      logic              seq_error;
      logic [SEQ_W-1:0]  next_seqnum;
   } result_type;

endpackage

// ===== rtl/packet_frame_reassembler.sv =====
// Length-prefixed frame reassembler. Each input beat carries one link byte and
// the sequence number expected for the next message; each accepted beat yields
// exactly one registered result beat. A new byte is accepted every cycle while the output
// skid entry is free: all header parsing, sequence checks and byte counting are done in
// one pass of counter and compare logic, and the two-entry output buffer keeps the input
// open while a result waits on the output. Payload bytes come out with tuser set, and
// tlast marks the beat that completes a message and carries its report.
// The maximum frame size register may be written only while the block is idle.
module packet_frame_reassembler import pfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration: maximum frame size.
   input  logic                  csr_wr_en,
   input  logic [LEN_W-1:0]      csr_wr_data,
   // Input stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] data_byte, [15:8] caller_seq
   input  logic [15:0]           req_tdata,
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] payload_out, [15:8] first_seq, [23:16] last_seq,
   // [55:24] message_bytes, [56] seq_error, [64:57] next_seqnum, [71:65] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // message_done
   output logic                  rsp_tlast,
   // [0] payload_valid
   output logic                  rsp_tuser
);

   logic       accept;
   result_type parse_res;
   result_type out_res;

   assign accept = req_tvalid && req_tready;

   pfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .data_byte   (req_tdata[7:0]),
      .caller_seq  (req_tdata[15:8]),
      .res         (parse_res)
   );

   pfr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_res    (parse_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   // Pack the result beat onto the stream ports.
   assign rsp_tdata = {7'b0, out_res.next_seqnum, out_res.seq_error,
                       out_res.message_bytes, out_res.last_seq,
                       out_res.first_seq, out_res.payload_out};
   assign rsp_tlast = out_res.message_done;
   assign rsp_tuser = out_res.payload_valid;

endmodule

// ===== rtl/pfr_parser.sv =====
module pfr_parser import pfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [SEQ_W-1:0]  caller_seq,
   output result_type        res
);

   logic              in_header_ff,    in_header_in;
   logic [1:0]        header_index_ff, header_index_in;
   logic [LEN_W-1:0]  length_shift_ff, length_shift_in;
   logic [LEN_W-1:0]  bytes_left_ff,   bytes_left_in;
   logic              first_frame_ff,  first_frame_in;
   logic [SEQ_W-1:0]  seq_first_ff,    seq_first_in;
   logic [SEQ_W-1:0]  seq_last_ff,     seq_last_in;
   logic              mismatch_ff,     mismatch_in;
   logic              continues_ff,    continues_in;
   logic [SIZE_W-1:0] size_count_ff,   size_count_in;
   logic [LEN_W-1:0]  max_frame_ff;

   logic              frame_end;
   logic              err;
   logic [SEQ_W-1:0]  want_seq;

   // Next state and result for the beat on the input.
   always_comb begin
      in_header_in    = in_header_ff;
      header_index_in = header_index_ff;
      length_shift_in = length_shift_ff;
      bytes_left_in   = bytes_left_ff;
      first_frame_in  = first_frame_ff;
      seq_first_in    = seq_first_ff;
      seq_last_in     = seq_last_ff;
      mismatch_in     = mismatch_ff;
      continues_in    = continues_ff;
      size_count_in   = size_count_ff;
      frame_end       = 1'b0;
      err             = 1'b0;
      want_seq        = seq_last_ff + SEQ_W'(1);
      res             = '0;

      if (in_header_ff) begin
         unique case (header_index_ff)
            2'd0: begin
               length_shift_in[7:0] = length_shift_ff[7:0] | data_byte;
               header_index_in      = header_index_ff + 2'd1;
            end
            2'd1: begin
               length_shift_in[15:8] = length_shift_ff[15:8] | data_byte;
               header_index_in       = header_index_ff + 2'd1;
            end
            2'd2: begin
               length_shift_in[23:16] = length_shift_ff[23:16] | data_byte;
               header_index_in        = header_index_ff + 2'd1;
            end
            default: begin
               // Sequence byte closes the header.
               if (first_frame_ff) begin
                  seq_first_in = data_byte;
                  seq_last_in  = data_byte;
               end else begin
                  if (data_byte != want_seq) begin
                     mismatch_in = 1'b1;
                  end
                  seq_last_in = want_seq;
               end
               bytes_left_in   = length_shift_ff;
               continues_in    = (length_shift_ff == max_frame_ff);
               first_frame_in  = 1'b0;
               header_index_in = 2'd0;
               length_shift_in = '0;
               in_header_in    = (length_shift_ff == '0);
               frame_end       = (length_shift_ff == '0);
            end
         endcase
      end else begin
         // Payload byte passes through.
         res.payload_valid = 1'b1;
         res.payload_out   = data_byte;
         if (size_count_ff != SIZE_MAX) begin
            size_count_in = size_count_ff + SIZE_W'(1);
         end
         bytes_left_in = bytes_left_ff - LEN_W'(1);
         if (bytes_left_in == '0) begin
            in_header_in = 1'b1;
            frame_end    = 1'b1;
         end
      end

      // Message report when a frame that is not continued ends.
      if (frame_end && !continues_in) begin
         err               = mismatch_in || (caller_seq != seq_first_in);
         res.message_done  = 1'b1;
         res.first_seq     = seq_first_in;
         res.last_seq      = seq_last_in;
         res.message_bytes = size_count_in;
         res.seq_error     = err;
         res.next_seqnum   = err ? caller_seq : seq_last_in + SEQ_W'(1);
         first_frame_in    = 1'b1;
         seq_first_in      = '0;
         seq_last_in       = '0;
         mismatch_in       = 1'b0;
         continues_in      = 1'b0;
         size_count_in     = '0;
      end
   end

   // Parser state advances on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff    <= 1'b1;
         header_index_ff <= 2'd0;
         length_shift_ff <= '0;
         bytes_left_ff   <= '0;
         first_frame_ff  <= 1'b1;
         seq_first_ff    <= '0;
         seq_last_ff     <= '0;
         mismatch_ff     <= 1'b0;
         continues_ff    <= 1'b0;
         size_count_ff   <= '0;
      end else if (accept) begin
         in_header_ff    <= in_header_in;
         header_index_ff <= header_index_in;
         length_shift_ff <= length_shift_in;
         bytes_left_ff   <= bytes_left_in;
         first_frame_ff  <= first_frame_in;
         seq_first_ff    <= seq_first_in;
         seq_last_ff     <= seq_last_in;
         mismatch_ff     <= mismatch_in;
         continues_ff    <= continues_in;
         size_count_ff   <= size_count_in;
      end
   end

   // Maximum frame size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
      end else if (csr_wr_en) begin
         max_frame_ff <= csr_wr_data;
      end
   end

   // The header counter only moves while a header is being collected.
   a_index_in_header: assert property (@(posedge clock) disable iff (reset)
      (header_index_ff != 2'd0) |-> in_header_ff)
      else $error("header index advanced outside a header");

   // A header beat never produces payload.
   a_header_no_payload: assert property (@(posedge clock) disable iff (reset)
      (accept && in_header_ff) |-> !res.payload_valid)
      else $error("header byte passed as payload");

   // A finished message leaves a clean message state behind.
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && res.message_done) |=>
         (first_frame_ff && size_count_ff == '0 && !mismatch_ff))
      else $error("message state not cleared after report");

endmodule

// ===== rtl/pfr_out_stage.sv =====
module pfr_out_stage import pfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_res,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       take_in;
   logic       take_out;

   // Two-entry buffer: a beat is taken as long as the skid entry is free.
   assign in_ready  = !skid_valid_ff;
   assign take_in   = in_valid && !skid_valid_ff;
   assign take_out  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take_out) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = take_in;
            main_in       = in_res;
         end
      end else if (take_in) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = in_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = in_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // The skid entry is only ever filled behind an occupied main entry.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry full while main entry empty");

endmodule

// ===== bench/tb_packet_frame_reassembler.sv =====
module tb_packet_frame_reassembler;
   import pfr_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 40;
   localparam logic [LEN_W-1:0] LONG_FRAME_LEN = 24'h000102;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [LEN_W-1:0]      csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   packet_frame_reassembler dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   // Shared bench state.
   result_type       expected_results[$];
   int               mismatch_count = 0;
   int               beats_sent = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;

   // Shadow copy of the parser state and the frame size register.
   logic [LEN_W-1:0]  max_frame_len;
   logic              in_hdr;
   logic [1:0]        hdr_pos;
   logic [LEN_W-1:0]  len_acc;
   logic [LEN_W-1:0]  remaining;
   logic              first_frm;
   logic [SEQ_W-1:0]  seq_first;
   logic [SEQ_W-1:0]  seq_last;
   logic              seq_bad;
   logic              cont;
   logic [SIZE_W-1:0] msg_bytes;

   // Clock.
   initial begin
      clock = 1'b0;
      forever begin
         #(CLK_PERIOD / 2) clock = ~clock;
      end
   end

   // Watchdog: end the run with an error once the cycle limit is reached.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: randomly stalls the result stream.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic void clear_message();
      first_frm = 1'b1;
      seq_first = '0;
      seq_last  = '0;
      seq_bad   = 1'b0;
      cont      = 1'b0;
      msg_bytes = '0;
   endfunction

   function automatic void reset_shadow();
      max_frame_len = MAX_FRAME_RESET;
      in_hdr        = 1'b1;
      hdr_pos       = '0;
      len_acc       = '0;
      remaining     = '0;
      clear_message();
   endfunction

   // Advance the shadow parser by one accepted byte and queue the result beat.
   function automatic void predict_beat(input logic [7:0] data_byte,
                                        input logic [7:0] exp_seq);
      result_type      r;
      logic            frame_end;
      logic            err;
      logic [SEQ_W-1:0] want;
      r = '0;
      frame_end = 1'b0;
      if (in_hdr) begin
         if (hdr_pos != HDR_SEQ_IDX) begin
            len_acc = len_acc | (LEN_W'(data_byte) << (8 * hdr_pos));
            hdr_pos = hdr_pos + 2'd1;
         end else begin
            if (first_frm) begin
               seq_first = data_byte;
               seq_last  = data_byte;
            end else begin
               want = seq_last + 8'd1;
               if (data_byte != want) begin
                  seq_bad = 1'b1;
               end
               seq_last = want;
            end
            remaining = len_acc;
            cont      = (len_acc == max_frame_len);
            first_frm = 1'b0;
            hdr_pos   = '0;
            len_acc   = '0;
            in_hdr    = 1'b0;
            if (remaining == '0) begin
               in_hdr    = 1'b1;
               frame_end = 1'b1;
            end
         end
      end else begin
         r.payload_valid = 1'b1;
         r.payload_out   = data_byte;
         if (msg_bytes != SIZE_MAX) begin
            msg_bytes = msg_bytes + 32'd1;
         end
         remaining = remaining - 24'd1;
         if (remaining == '0) begin
            in_hdr    = 1'b1;
            frame_end = 1'b1;
         end
      end
      // A frame that is not continued closes the message and reports it.
      if (frame_end && !cont) begin
         err             = seq_bad || (exp_seq != seq_first);
         r.message_done  = 1'b1;
         r.first_seq     = seq_first;
         r.last_seq      = seq_last;
         r.message_bytes = msg_bytes;
         r.seq_error     = err;
         r.next_seqnum   = err ? exp_seq : seq_last + 8'd1;
         clear_message();
      end
      expected_results.push_back(r);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // Checker: capture each result beat at the rising edge, compare it afterwards.
   initial begin : result_checker
      logic                  fired;
      logic [RSP_DATA_W-1:0] cap_data;
      logic                  cap_last;
      logic                  cap_user;
      result_type            want;
      forever begin
         @(posedge clock);
         fired    = !reset && rsp_tvalid && rsp_tready;
         cap_data = rsp_tdata;
         cap_last = rsp_tlast;
         cap_user = rsp_tuser;
         @(negedge clock);
         if (fired) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("payload_valid", 32'(cap_user), 32'(want.payload_valid));
               check_field("payload_out", 32'(cap_data[7:0]), 32'(want.payload_out));
               check_field("message_done", 32'(cap_last), 32'(want.message_done));
               check_field("first_seq", 32'(cap_data[15:8]), 32'(want.first_seq));
               check_field("last_seq", 32'(cap_data[23:16]), 32'(want.last_seq));
               check_field("message_bytes", cap_data[55:24], want.message_bytes);
               check_field("seq_error", 32'(cap_data[56]), 32'(want.seq_error));
               check_field("next_seqnum", 32'(cap_data[64:57]), 32'(want.next_seqnum));
            end
         end
      end
   end

   // Send one byte; called at a falling edge with tvalid low, returns likewise.
   task automatic send_byte(input logic [7:0] data_byte, input logic [7:0] exp_seq);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {exp_seq, data_byte};
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_beat(data_byte, exp_seq);
      beats_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // One frame: length bytes low first, the sequence byte, then the payload.
   // The caller's expected number rides on the frame's final beat.
   task automatic send_frame(input logic [LEN_W-1:0] len, input logic [7:0] seq,
                             input logic [7:0] exp_seq);
      send_byte(len[7:0], 8'($urandom_range(255)));
      send_byte(len[15:8], 8'($urandom_range(255)));
      send_byte(len[23:16], 8'($urandom_range(255)));
      send_byte(seq, (len == '0) ? exp_seq : 8'($urandom_range(255)));
      for (int i = 1; i <= int'(len); i++) begin
         send_byte(8'($urandom_range(255)),
                   (i == int'(len)) ? exp_seq : 8'($urandom_range(255)));
      end
   endtask

   task automatic wait_all_results();
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Register writes happen only once the block has gone quiet.
   task automatic set_max_frame(input logic [LEN_W-1:0] value);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      max_frame_len = value;
   endtask

   // Reset default maximum: a single frame, payload extremes, sequence wrap to zero.
   task automatic test_default_max();
      send_byte(8'h02, 8'h00);
      send_byte(8'h00, 8'h00);
      send_byte(8'h00, 8'h00);
      send_byte(8'hFF, 8'h00);
      send_byte(8'h00, 8'h00);
      send_byte(8'hFF, 8'hFF);
   endtask

   // Empty frame ends on its sequence byte; expected number does not match.
   task automatic test_empty_frame();
      send_frame(24'd0, 8'h00, 8'h80);
   endtask

   // Continued frames with wrap inside the message, then a broken sequence.
   task automatic test_continued_frames();
      set_max_frame(24'd1);
      send_frame(24'd1, 8'hFE, 8'h00);
      send_frame(24'd1, 8'hFF, 8'h00);
      send_frame(24'd2, 8'h00, 8'hFE);
      send_frame(24'd1, 8'h05, 8'h05);
      send_frame(24'd0, 8'h09, 8'h05);
   endtask

   // A zero maximum makes every empty frame a continued one.
   task automatic test_zero_max();
      set_max_frame(24'd0);
      send_frame(24'd0, 8'h07, 8'h07);
      send_frame(24'd0, 8'h08, 8'h07);
      send_frame(24'd1, 8'h09, 8'h07);
   endtask

   // A frame using two length bytes, continued into a short one.
   task automatic test_long_frame();
      set_max_frame(LONG_FRAME_LEN);
      send_frame(LONG_FRAME_LEN, 8'h40, 8'h00);
      send_frame(24'd3, 8'h41, 8'h40);
   endtask

   // Random messages: mostly well-formed chains, some with bad sequence numbers
   // or a wrong expected number.
   task automatic test_random_traffic(input int n_beats, input logic [LEN_W-1:0] max_len);
      int               target;
      int               frames;
      int               last_len;
      bit               broken;
      logic [7:0]       seq0;
      logic [7:0]       seq;
      logic [7:0]       exp_seq;
      logic [LEN_W-1:0] len;
      set_max_frame(max_len);
      target = beats_sent + n_beats;
      while (beats_sent < target) begin
         frames  = (max_frame_len <= 24'd8) ? $urandom_range(1, 4) : 1;
         broken  = ($urandom_range(99) < 15);
         seq0    = 8'($urandom_range(255));
         exp_seq = ($urandom_range(99) < 75) ? seq0 : 8'($urandom_range(255));
         seq     = seq0;
         for (int f = 0; f < frames; f++) begin
            if (f == frames - 1) begin
               last_len = $urandom_range(0, 7);
               len = LEN_W'(last_len);
               if (len == max_frame_len) begin
                  len = len + 24'd1;
               end
            end else begin
               len = max_frame_len;
            end
            if (broken && f > 0 && $urandom_range(1) == 1) begin
               send_frame(len, seq ^ 8'($urandom_range(1, 255)), exp_seq);
            end else begin
               send_frame(len, seq, exp_seq);
            end
            seq = seq + 8'd1;
         end
      end
   endtask

   // Test sequence.
   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      reset_shadow();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Sender rarely idle, receiver often stalled.
      sender_idle_pct    = 8;
      receiver_stall_pct = 53;
      test_default_max();
      test_empty_frame();
      test_continued_frames();
      test_zero_max();
      test_random_traffic(180, 24'd3);
      test_random_traffic(170, 24'd0);

      // Sender often idle, receiver rarely stalled.
      sender_idle_pct    = 53;
      receiver_stall_pct = 8;
      test_random_traffic(180, 24'd1);
      test_random_traffic(170, MAX_FRAME_RESET);

      // Full rate on both sides.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_long_frame();
      test_random_traffic(170, 24'd5);
      test_random_traffic(160, 24'd2);

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== packet_frame_reassembler.f =====
rtl/pfr_pkg.sv
rtl/pfr_parser.sv
rtl/pfr_out_stage.sv
rtl/packet_frame_reassembler.sv
bench/tb_packet_frame_reassembler.sv
